FILE: src/lfucl_pkg.sv
// Shared constants, types and state codes for the LFU cache with LRU tie break.
package lfucl_pkg;

  // Number of slots in the entry store
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Holds 0..CAPACITY (occupancy and scan counter)
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int UCNT_W   = 32;
  localparam int CAPCFG_W = 5;

  localparam logic [CAPCFG_W-1:0] CAP_RESET = CAPCFG_W'(16);
  localparam logic [UCNT_W-1:0]   UCNT_MAX  = {UCNT_W{1'b1}};
  localparam logic [UCNT_W-1:0]   UCNT_ONE  = UCNT_W'(1);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // One word of the entry store
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [UCNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of one scan over all slots
  typedef struct packed {
    logic              found_ok;
    logic [IDX_W-1:0]  found_idx;
    logic [IDX_W-1:0]  found_rank;
    logic [DATA_W-1:0] found_data;
    logic [UCNT_W-1:0] found_count;
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              victim_ok;
    logic [IDX_W-1:0]  victim_idx;
    logic [IDX_W-1:0]  victim_rank;
    logic [UCNT_W-1:0] victim_count;
    logic [OCC_W-1:0]  used;
  } scan_res_t;

  // Recency update request
  typedef struct packed {
    logic             en;
    logic             fresh;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rank;
  } touch_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

FILE: src/lfucl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfucl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lfucl_age.sv
// Slot valid bits and recency ranks, with registered lookup and recency update.
module lfucl_age
  import lfucl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_valid,
  output logic [IDX_W-1:0] rd_rank,
  input  touch_t           touch
);

  logic [CAPACITY-1:0] valid_r;
  logic [CAPACITY-1:0] valid_nxt;
  logic [IDX_W-1:0]    rank_r   [CAPACITY];
  logic [IDX_W-1:0]    rank_nxt [CAPACITY];
  logic                rd_valid_r;
  logic [IDX_W-1:0]    rd_rank_r;

  // Recency update: touched slot to rank 0; newer (all if fresh) age by one
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch.en) begin
        if (IDX_W'(i) == touch.idx) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i] && (touch.fresh || (rank_r[i] < touch.rank))) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Lookup aligned with the entry RAM read latency
  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[rd_addr];
    rd_rank_r  <= rank_r[rd_addr];
  end

  assign rd_valid = rd_valid_r;
  assign rd_rank  = rd_rank_r;

`ifndef SYNTH
  // Entries never disappear
  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) >= $countones($past(valid_r)))
    else $error("valid entry lost");

  // Touched slot is valid and most recent afterwards
  a_touch_result: assert property (@(posedge clk) disable iff (!rst_n)
    touch.en |=> valid_r[$past(touch.idx)] && (rank_r[$past(touch.idx)] == '0))
    else $error("touched slot not most recent");

  // Ranks of valid entries stay below the occupancy
  for (genvar g = 0; g < CAPACITY; g++) begin : g_rank_chk
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r[g] |-> (int'(rank_r[g]) < $countones(valid_r)))
      else $error("rank out of range");
  end
`endif

endmodule

FILE: src/lfucl_scan.sv
// Scan accumulator: key match, first free slot, eviction victim and occupancy.
module lfucl_scan
  import lfucl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic             rd_vld,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             rd_valid,
  input  logic [IDX_W-1:0] rd_rank,
  input  entry_t           rd_entry,
  output scan_res_t        res
);

  scan_res_t res_r;
  scan_res_t res_nxt;
  logic      better;

  // Lower count wins; equal count goes to the older entry
  assign better = !res_r.victim_ok ||
                  (rd_entry.count < res_r.victim_count) ||
                  ((rd_entry.count == res_r.victim_count) && (rd_rank > res_r.victim_rank));

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt.found_ok  = 1'b0;
      res_nxt.free_ok   = 1'b0;
      res_nxt.victim_ok = 1'b0;
      res_nxt.used      = '0;
    end else if (rd_vld) begin
      if (rd_valid) begin
        res_nxt.used = res_r.used + OCC_W'(1);
        if (rd_entry.key == key) begin
          res_nxt.found_ok    = 1'b1;
          res_nxt.found_idx   = rd_idx;
          res_nxt.found_rank  = rd_rank;
          res_nxt.found_data  = rd_entry.data;
          res_nxt.found_count = rd_entry.count;
        end
        if (better) begin
          res_nxt.victim_ok    = 1'b1;
          res_nxt.victim_idx   = rd_idx;
          res_nxt.victim_rank  = rd_rank;
          res_nxt.victim_count = rd_entry.count;
        end
      end else if (!res_r.free_ok) begin
        res_nxt.free_ok  = 1'b1;
        res_nxt.free_idx = rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: src/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with least-recently-used tie break.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_op, in_key, in_value
//   out_    | output    | out_valid/out_stall| out_hit, out_read_value
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_data (capacity_in_use)
//
// Each request passes through an accept step, a scan that reads the entry RAM
// one slot per cycle on its single read port (read data is registered), a
// write-back step and a response step. With capacity zero the scan and the
// write-back are skipped.
// Reset (rst_n low, synchronous) clears all entries and sets capacity to 16.
// A new request is taken while the previous response still waits on out_stall.
module lfu_cache_lru_tiebreak
  import lfucl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [DATA_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [DATA_W-1:0]   out_read_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAPCFG_W-1:0] cfg_data
);

  state_t              state_r, state_nxt;
  logic [OCC_W-1:0]    cnt_r, cnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [DATA_W-1:0]   val_r;
  logic [CAPCFG_W-1:0] cap_r;
  logic                resp_hit_r, resp_hit_nxt;
  logic [DATA_W-1:0]   resp_data_r, resp_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_load;
  logic                accept;
  logic                scan_start;
  logic [IDX_W-1:0]    rd_addr;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  logic                age_valid;
  logic [IDX_W-1:0]    age_rank;
  touch_t              touch;
  scan_res_t           scan_res;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_addr   = cnt_r[IDX_W-1:0];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // Sequencer: scan, write back, respond
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    scan_start    = 1'b0;
    resp_hit_nxt  = resp_hit_r;
    resp_data_nxt = resp_data_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    touch         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt    = '0;
          scan_start = 1'b1;
          if (cap_r == '0) begin
            resp_hit_nxt  = 1'b0;
            resp_data_nxt = '0;
            state_nxt     = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r < OCC_W'(CAPACITY)) begin
          rd_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + OCC_W'(1);
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        resp_hit_nxt  = scan_res.found_ok;
        resp_data_nxt = (scan_res.found_ok && (op_r == OP_GET)) ? scan_res.found_data : '0;
        ram_wdata.key = key_r;
        if (scan_res.found_ok) begin
          // Hit: bump count, replace data on put
          ram_we          = 1'b1;
          ram_waddr       = scan_res.found_idx;
          ram_wdata.data  = (op_r == OP_PUT) ? val_r : scan_res.found_data;
          ram_wdata.count = (scan_res.found_count == UCNT_MAX) ? UCNT_MAX :
                            scan_res.found_count + UCNT_ONE;
          touch.en        = 1'b1;
          touch.idx       = scan_res.found_idx;
          touch.rank      = scan_res.found_rank;
        end else if (op_r == OP_PUT) begin
          // Miss on put: fill a free slot or evict the victim
          ram_wdata.data  = val_r;
          ram_wdata.count = UCNT_ONE;
          if ((int'(scan_res.used) < int'(cap_r)) && scan_res.free_ok) begin
            ram_we      = 1'b1;
            ram_waddr   = scan_res.free_idx;
            touch.en    = 1'b1;
            touch.fresh = 1'b1;
            touch.idx   = scan_res.free_idx;
          end else if (scan_res.victim_ok) begin
            ram_we     = 1'b1;
            ram_waddr  = scan_res.victim_idx;
            touch.en   = 1'b1;
            touch.idx  = scan_res.victim_idx;
            touch.rank = scan_res.victim_rank;
          end
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_addr;
    resp_hit_r  <= resp_hit_nxt;
    resp_data_r <= resp_data_nxt;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r  <= resp_hit_r;
      out_data_r <= resp_data_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_data_r;

  // Entry store: key, data and use count per slot
  lfucl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  lfucl_age u_age (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_valid (age_valid),
    .rd_rank  (age_rank),
    .touch    (touch)
  );

  lfucl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .key      (key_r),
    .rd_vld   (rd_pend_r),
    .rd_idx   (rd_idx_r),
    .rd_valid (age_valid),
    .rd_rank  (age_rank),
    .rd_entry (ram_rdata),
    .res      (scan_res)
  );

`ifndef SYNTH
  // Entry store is only written in the write-back step
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WRITE))
    else $error("entry write outside write-back");

  // A miss on get leaves the store untouched
  a_get_miss_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WRITE) && !scan_res.found_ok && (op_r == OP_GET)) |-> !ram_we && !touch.en)
    else $error("get miss modified state");

  // A stalled response stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_hit) && $stable(out_read_value))
    else $error("stalled response changed");
`endif

endmodule

FILE: tb/lfu_cache_lru_tiebreak_test.sv
// Self-checking testbench for the LFU cache with LRU tie break.
module lfu_cache_lru_tiebreak_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfucl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int KEY_POOL    = 22;
  localparam int DIR_ROWS    = 24;
  localparam int DRAIN_WAIT  = 4;
  localparam int TAIL_WAIT   = 40;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [KEY_W-1:0]    in_key;
  logic [DATA_W-1:0]   in_value;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [DATA_W-1:0]   out_read_value;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAPCFG_W-1:0] cfg_data;

  lfu_cache_lru_tiebreak dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Expected response of one request
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] rd;
  } resp_t;

  // One directed row: either a capacity write or a request
  typedef struct packed {
    logic                is_cfg;
    logic [CAPCFG_W-1:0] cap;
    logic                op;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   val;
    logic                known;
    logic                hit;
    logic [DATA_W-1:0]   rd;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty cache after reset, then extremes of key and value
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
    // put hit reports hit with zero data
    '{1'b0, 5'd0,  OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // cache disabled
    '{1'b1, 5'd0,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'h0000_0005, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // register above the slot count acts as full capacity
    '{1'b1, 5'd31, OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // capacity lowered below occupancy: one victim per new key
    '{1'b1, 5'd1,  OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'h5555_5555, 32'h5555_5555, 1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'h0000_0009, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // back to full size
    '{1'b1, 5'd16, OP_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_PUT, 32'h0000_0077, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0077, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  localparam logic [CAPCFG_W-1:0] PHASE_CAP [NUM_PHASES] = '{
    5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5, 5'd0, 5'd12
  };

  // Cache image kept by the testbench
  logic [CAPCFG_W-1:0] cap_reg;
  bit                  slot_valid [CAPACITY];
  logic [KEY_W-1:0]    slot_key   [CAPACITY];
  logic [DATA_W-1:0]   slot_data  [CAPACITY];
  logic [UCNT_W-1:0]   slot_count [CAPACITY];
  int                  slot_age   [CAPACITY];

  resp_t             pending_resp [$];
  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  int                send_idle_pct;
  int                stall_pct;
  int                n_errors;
  int                n_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Make slot s the most recent entry
  function automatic void bump_recency(int s, bit fresh);
    int r;
    r = slot_age[s];
    for (int i = 0; i < CAPACITY; i++) begin
      if (i != s && slot_valid[i] && (fresh || slot_age[i] < r))
        slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Apply one get or put to the cache image and return its response
  function automatic resp_t cache_access(logic op, logic [KEY_W-1:0] key,
                                         logic [DATA_W-1:0] val);
    resp_t r;
    int    cap;
    int    used;
    int    found;
    int    freeslot;
    int    victim;
    int    s;
    bit    fresh;
    r        = '0;
    cap      = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
    used     = 0;
    found    = -1;
    freeslot = -1;
    victim   = -1;
    if (cap == 0)
      return r;
    // scan: match, free slot, eviction candidate
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i]) begin
        used++;
        if (slot_key[i] == key)
          found = i;
        if (victim < 0 || slot_count[i] < slot_count[victim] ||
            (slot_count[i] == slot_count[victim] && slot_age[i] > slot_age[victim]))
          victim = i;
      end else if (freeslot < 0) begin
        freeslot = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == OP_GET)
        r.rd = slot_data[found];
      else
        slot_data[found] = val;
      if (slot_count[found] != UCNT_MAX)
        slot_count[found]++;
      bump_recency(found, 1'b0);
      return r;
    end
    if (op == OP_PUT) begin
      if (used < cap && freeslot >= 0) begin
        s     = freeslot;
        fresh = 1'b1;
      end else if (victim >= 0) begin
        s     = victim;
        fresh = 1'b0;
      end else begin
        return r;
      end
      slot_valid[s] = 1'b1;
      slot_key[s]   = key;
      slot_data[s]  = val;
      slot_count[s] = UCNT_ONE;
      bump_recency(s, fresh);
    end
    return r;
  endfunction

  // Issue one request; a known row supplies its own expected response
  task automatic send_req(logic op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val,
                          bit known, resp_t typed);
    resp_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_value <= val;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    p = cache_access(op, key, val);
    pending_resp.push_back(known ? typed : p);
  endtask

  // Let the cache drain, then write the capacity register
  task automatic write_capacity(logic [CAPCFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_resp.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  // Response stall pattern
  always @(posedge clk) begin
    out_stall <= rst_n && stall_pct > 0 && ($urandom_range(99) < stall_pct);
  end

  // Response checker
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected response hit %0d read_value %h",
                 $time, out_hit, out_read_value);
      end else begin
        e = pending_resp.pop_front();
        if (out_hit !== e.hit) begin
          n_errors++;
          $display("%0t: hit mismatch expected %0d actual %0d", $time, e.hit, out_hit);
        end
        if (out_read_value !== e.rd) begin
          n_errors++;
          $display("%0t: read_value mismatch expected %h actual %h",
                   $time, e.rd, out_read_value);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic              op;
    logic [KEY_W-1:0]  key;
    resp_t             typed;
    n_errors      = 0;
    n_cycles      = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_op     <= OP_GET;
    in_key    <= '0;
    in_value  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    // cache image after reset
    cap_reg = CAP_RESET;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_data[i]  = '0;
      slot_count[i] = '0;
      slot_age[i]   = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        write_capacity(DIR_TAB[i].cap);
      end else begin
        typed.hit = DIR_TAB[i].hit;
        typed.rd  = DIR_TAB[i].rd;
        send_req(DIR_TAB[i].op, DIR_TAB[i].key, DIR_TAB[i].val, DIR_TAB[i].known, typed);
      end
    end

    // random phases: new capacity, new key pool, rotating idle and stall pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(PHASE_CAP[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int k = 0; k < KEY_POOL; k++)
        key_pool[k] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op  = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
        key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom;
        send_req(op, key, $urandom, 1'b0, '0);
      end
    end

    // wait out the remaining responses
    in_valid <= 1'b0;
    while (pending_resp.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0 && pending_resp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
